@@ hdl/bpu_pkg.sv @@
// Shared types, codes and helpers of the branch predictor unit.
`default_nettype none

package bpu_pkg;

   // 2-bit saturating counter
   typedef logic [1:0] cnt_type;

   localparam cnt_type CNT_WEAK_TAKEN   = 2'd2;
   localparam cnt_type CNT_WEAK_BIMODAL = 2'd1;
   localparam cnt_type CNT_TAKEN_MIN    = 2'd2;
   localparam cnt_type CNT_MAX          = 2'd3;
   localparam cnt_type CNT_MIN          = 2'd0;

   // Predictor modes; any code above gshare runs as hybrid
   localparam logic [1:0] MODE_BIMODAL = 2'd0;
   localparam logic [1:0] MODE_GSHARE  = 2'd1;

   // Configuration channel
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE         = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIMODAL_BITS = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GSHARE_BITS  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HISTORY_BITS = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHOOSER_BITS = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BTB_ENABLE   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BTB_SET_BITS = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BTB_WAYS     = 4'd7;

   // Control carried with a transaction into the direction stage
   typedef struct packed {
      logic hybrid;
      logic gshare;
      logic consulted;
      logic taken;
   } dir_ctl_type;

   // Result of the direction stage
   typedef struct packed {
      logic predicted_taken;
      logic mispredicted;
      logic predictor_consulted;
      logic chose_gshare;
   } dir_res_type;

   // Counter write-back requests
   typedef struct packed {
      logic    bi_we;
      cnt_type bi_val;
      logic    gs_we;
      cnt_type gs_val;
      logic    ch_we;
      cnt_type ch_val;
   } dir_wr_type;

   function automatic cnt_type sat_step(input cnt_type c, input logic up);
      cnt_type r;
      if (up) begin
         r = (c == CNT_MAX) ? CNT_MAX : cnt_type'(c + 2'd1);
      end else begin
         r = (c == CNT_MIN) ? CNT_MIN : cnt_type'(c - 2'd1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/bpu_if.sv @@
// Channel interfaces of the branch predictor unit.
`default_nettype none

interface bpu_req_if #(parameter int ADDRESS_BITS = 24) ();
   logic                    valid;
   logic                    ready;
   logic [ADDRESS_BITS-1:0] branch_address;
   logic                    taken;
   modport source (output valid, branch_address, taken, input ready);
   modport sink   (input valid, branch_address, taken, output ready);
endinterface

interface bpu_rsp_if ();
   logic valid;
   logic ready;
   logic predicted_taken;
   logic mispredicted;
   logic predictor_consulted;
   logic chose_gshare;
   modport source (output valid, predicted_taken, mispredicted, predictor_consulted,
                   chose_gshare, input ready);
   modport sink   (input valid, predicted_taken, mispredicted, predictor_consulted,
                   chose_gshare, output ready);
endinterface

interface bpu_csr_if ();
   logic                            valid;
   logic                            ready;
   logic [bpu_pkg::CSR_INDEX_W-1:0] index;
   logic [bpu_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/bpu_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module bpu_ram #(
   parameter int WIDTH  = 2,
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = 14
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/bpu_btb_lru.sv @@
// BTB set lookup with true-LRU rank update and victim fill.
`default_nettype none

module bpu_btb_lru #(
   parameter int WAYS   = 4,
   parameter int TAG_W  = 22,
   parameter int RANK_W = 2
) (
   input  wire logic [WAYS*RANK_W-1:0] rank_vec,
   input  wire logic [WAYS-1:0]        valid_vec,
   input  wire logic [WAYS*TAG_W-1:0]  tag_vec,
   input  wire logic [WAYS-1:0]        way_act,
   input  wire logic [TAG_W-1:0]       tag,
   output      logic                   hit,
   output      logic [WAYS*RANK_W-1:0] new_rank_vec,
   output      logic [WAYS-1:0]        new_valid_vec,
   output      logic [WAYS*TAG_W-1:0]  new_tag_vec
);

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic [RANK_W-1:0] rk [WAYS];
   logic [TAG_W-1:0]  tg [WAYS];
   logic [RANK_W-1:0] nrk [WAYS];
   logic              any_inv;
   logic              found;
   logic [RANK_W-1:0] best;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  vic_way;
   logic [WAY_W-1:0]  sel;
   logic [RANK_W-1:0] sel_rank;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      any_inv = 1'b0;
      found   = 1'b0;
      best    = '0;
      vic_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         rk[w] = rank_vec[w*RANK_W +: RANK_W];
         tg[w] = tag_vec[w*TAG_W +: TAG_W];
      end
      // first valid matching way
      for (int w = 0; w < WAYS; w++) begin
         if (way_act[w] && valid_vec[w] && (tg[w] == tag) && !hit) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (way_act[w] && !valid_vec[w]) begin
            any_inv = 1'b1;
         end
      end
      // victim: oldest among invalid ways if any, else oldest overall
      for (int w = 0; w < WAYS; w++) begin
         if (way_act[w] && (!any_inv || !valid_vec[w]) && (!found || (rk[w] > best))) begin
            found   = 1'b1;
            best    = rk[w];
            vic_way = WAY_W'(w);
         end
      end
      sel      = hit ? hit_way : vic_way;
      sel_rank = rk[sel];
      // age ways younger than the touched one
      for (int w = 0; w < WAYS; w++) begin
         nrk[w] = (way_act[w] && (rk[w] < sel_rank)) ? RANK_W'(rk[w] + 1'b1) : rk[w];
      end
      nrk[sel]      = '0;
      new_valid_vec = valid_vec;
      new_tag_vec   = tag_vec;
      if (!hit) begin
         new_valid_vec[sel]               = 1'b1;
         new_tag_vec[sel*TAG_W +: TAG_W] = tag;
      end
      for (int w = 0; w < WAYS; w++) begin
         new_rank_vec[w*RANK_W +: RANK_W] = nrk[w];
      end
   end

endmodule

`default_nettype wire

@@ hdl/bpu_dir.sv @@
// Direction stage: prediction, chooser decision and counter training.
`default_nettype none

module bpu_dir (
   input  wire bpu_pkg::dir_ctl_type ctl,
   input  wire bpu_pkg::cnt_type     bi_cnt,
   input  wire bpu_pkg::cnt_type     gs_cnt,
   input  wire bpu_pkg::cnt_type     ch_cnt,
   output      bpu_pkg::dir_res_type res,
   output      bpu_pkg::dir_wr_type  wr
);

   logic pb;
   logic pg;
   logic chose;
   logic pred;

   always_comb begin
      pb    = (bi_cnt >= bpu_pkg::CNT_TAKEN_MIN);
      pg    = (gs_cnt >= bpu_pkg::CNT_TAKEN_MIN);
      chose = ctl.hybrid && (ch_cnt >= bpu_pkg::CNT_TAKEN_MIN);
      pred  = 1'b0;
      wr        = '0;
      wr.bi_val = bpu_pkg::sat_step(bi_cnt, ctl.taken);
      wr.gs_val = bpu_pkg::sat_step(gs_cnt, ctl.taken);
      wr.ch_val = bpu_pkg::sat_step(ch_cnt, pg == ctl.taken);
      if (ctl.hybrid) begin
         // train only the chosen side; chooser moves when exactly one was right
         pred     = chose ? pg : pb;
         wr.gs_we = chose;
         wr.bi_we = !chose;
         wr.ch_we = ((pb == ctl.taken) != (pg == ctl.taken));
      end else if (ctl.consulted) begin
         if (ctl.gshare) begin
            pred     = pg;
            wr.gs_we = 1'b1;
         end else begin
            pred     = pb;
            wr.bi_we = 1'b1;
         end
      end
      res.predicted_taken     = pred;
      res.mispredicted        = pred ^ ctl.taken;
      res.predictor_consulted = ctl.consulted;
      res.chose_gshare        = chose;
   end

endmodule

`default_nettype wire

@@ hdl/branch_predictor_unit.sv @@
// Pipeline: an accepted transaction moves through the stage 1, stage 2 and result registers.
// Throughput: one branch per cycle while rsp_bus.ready lets the pipeline advance, set by
// the single read and write port of each counter RAM and the BTB RAM, with one-deep
// write-to-read forwarding. Reset: synchronous; registers clear at once, then a clearing
// pass over max(2**MAX_TABLE_BITS, BTB_SETS) addresses (16384 by default) fills the RAMs
// while req_bus.ready stays low. Configuration writes are taken throughout.
`default_nettype none

module branch_predictor_unit #(
   parameter int MAX_TABLE_BITS   = 14,
   parameter int MAX_HISTORY_BITS = 14,
   parameter int BTB_SETS         = 256,
   parameter int BTB_WAYS         = 4,
   parameter int ADDRESS_BITS     = 24
) (
   input wire logic  clock,
   input wire logic  reset,
   bpu_req_if.sink   req_bus,
   bpu_rsp_if.source rsp_bus,
   bpu_csr_if.sink   csr_bus
);

   localparam int TB      = MAX_TABLE_BITS;
   localparam int HB      = MAX_HISTORY_BITS;
   localparam int TDEPTH  = 1 << TB;
   localparam int SET_W   = (BTB_SETS > 1) ? $clog2(BTB_SETS) : 1;
   localparam int SET_LOG = $clog2(BTB_SETS + 1) - 1;
   localparam int RANK_W  = (BTB_WAYS > 1) ? $clog2(BTB_WAYS) : 1;
   localparam int WORD_W  = ADDRESS_BITS - 2;
   localparam int TAG_W   = ADDRESS_BITS - 2;
   localparam int ROW_W   = BTB_WAYS * (RANK_W + 1 + TAG_W);
   localparam int CLR_N   = (TDEPTH > BTB_SETS) ? TDEPTH : BTB_SETS;
   localparam int CLR_W   = $clog2(CLR_N + 1);

   // ---------------- configuration registers ----------------
   logic [1:0] mode_ff;
   logic [3:0] bimodal_bits_ff, gshare_bits_ff, history_bits_ff, chooser_bits_ff;
   logic       btb_enable_ff;
   logic [3:0] btb_set_bits_ff;
   logic [2:0] btb_ways_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= bpu_pkg::MODE_BIMODAL;
         bimodal_bits_ff <= 4'd14;
         gshare_bits_ff  <= 4'd14;
         history_bits_ff <= 4'd8;
         chooser_bits_ff <= 4'd14;
         btb_enable_ff   <= 1'b0;
         btb_set_bits_ff <= 4'd8;
         btb_ways_ff     <= 3'd4;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bpu_pkg::CSR_MODE:         mode_ff         <= csr_bus.data[1:0];
            bpu_pkg::CSR_BIMODAL_BITS: bimodal_bits_ff <= csr_bus.data[3:0];
            bpu_pkg::CSR_GSHARE_BITS:  gshare_bits_ff  <= csr_bus.data[3:0];
            bpu_pkg::CSR_HISTORY_BITS: history_bits_ff <= csr_bus.data[3:0];
            bpu_pkg::CSR_CHOOSER_BITS: chooser_bits_ff <= csr_bus.data[3:0];
            bpu_pkg::CSR_BTB_ENABLE:   btb_enable_ff   <= csr_bus.data[0];
            bpu_pkg::CSR_BTB_SET_BITS: btb_set_bits_ff <= csr_bus.data[3:0];
            bpu_pkg::CSR_BTB_WAYS:     btb_ways_ff     <= csr_bus.data[2:0];
            default: ;
         endcase
      end
   end

   // Effective sizes
   logic [4:0]          mb, mg, mk, hn, sb;
   logic [4:0]          ways_eff;
   logic [BTB_WAYS-1:0] way_act;
   logic                hybrid;

   always_comb begin
      mb = (bimodal_bits_ff == 4'd0) ? 5'd1 :
           (({1'b0, bimodal_bits_ff} > 5'(TB)) ? 5'(TB) : {1'b0, bimodal_bits_ff});
      mg = (gshare_bits_ff == 4'd0) ? 5'd1 :
           (({1'b0, gshare_bits_ff} > 5'(TB)) ? 5'(TB) : {1'b0, gshare_bits_ff});
      mk = (chooser_bits_ff == 4'd0) ? 5'd1 :
           (({1'b0, chooser_bits_ff} > 5'(TB)) ? 5'(TB) : {1'b0, chooser_bits_ff});
      hn = ({1'b0, history_bits_ff} > mg) ? mg : {1'b0, history_bits_ff};
      if (hn > 5'(HB)) begin
         hn = 5'(HB);
      end
      sb = ({1'b0, btb_set_bits_ff} > 5'(SET_LOG)) ? 5'(SET_LOG) : {1'b0, btb_set_bits_ff};
      ways_eff = (btb_ways_ff == 3'd0) ? 5'd1 :
                 (({2'b00, btb_ways_ff} > 5'(BTB_WAYS)) ? 5'(BTB_WAYS) : {2'b00, btb_ways_ff});
      for (int w = 0; w < BTB_WAYS; w++) begin
         way_act[w] = (5'(w) < ways_eff);
      end
      hybrid = (mode_ff != bpu_pkg::MODE_BIMODAL) && (mode_ff != bpu_pkg::MODE_GSHARE);
   end

   // ---------------- clearing pass ----------------
   logic             clr_active_ff, clr_active_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         clr_cnt_in = CLR_W'(clr_cnt_ff + 1'b1);
         if (clr_cnt_ff == CLR_W'(CLR_N - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   // ---------------- stage 0: accept, BTB read ----------------
   logic adv;
   logic accept;

   logic                 rsp_valid_ff;
   bpu_pkg::dir_res_type rsp_res_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv && !clr_active_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   logic [WORD_W-1:0] word0;
   logic [SET_W-1:0]  set0;
   logic [TAG_W-1:0]  tag0;

   always_comb begin
      word0 = req_bus.branch_address[ADDRESS_BITS-1:2];
      set0  = SET_W'(word0) & ~({SET_W{1'b1}} << sb);
      tag0  = TAG_W'(word0 >> sb);
   end

   // ---------------- stage 1: BTB update, index, history ----------------
   logic                    s1_valid_ff;
   logic [ADDRESS_BITS-1:0] s1_addr_ff;
   logic                    s1_taken_ff;
   logic [SET_W-1:0]        s1_set_ff;
   logic [TAG_W-1:0]        s1_tag_ff;
   logic [HB-1:0]           hist_ff, hist_in;

   logic [ROW_W-1:0] btb_rd;
   logic [ROW_W-1:0] btb_row;
   logic [ROW_W-1:0] btb_new_row;
   logic [ROW_W-1:0] btb_rst_row;
   logic             btb_wb_en_ff;
   logic [SET_W-1:0] btb_wb_set_ff;
   logic [ROW_W-1:0] btb_wb_row_ff;
   logic             btb_use;
   logic             btb_hit;
   logic             consulted;
   logic             btb_wr_en;
   logic [SET_W-1:0] btb_wr_addr;
   logic [ROW_W-1:0] btb_wr_data;

   localparam int RK_LO = 0;
   localparam int VL_LO = BTB_WAYS * RANK_W;
   localparam int TG_LO = VL_LO + BTB_WAYS;

   // forward the previous write of the same set
   assign btb_row = (btb_wb_en_ff && (btb_wb_set_ff == s1_set_ff)) ? btb_wb_row_ff : btb_rd;

   always_comb begin
      btb_rst_row = '0;
      for (int w = 0; w < BTB_WAYS; w++) begin
         btb_rst_row[RK_LO + w*RANK_W +: RANK_W] = RANK_W'(w);
      end
   end

   bpu_btb_lru #(
      .WAYS   (BTB_WAYS),
      .TAG_W  (TAG_W),
      .RANK_W (RANK_W)
   ) u_btb_lru (
      .rank_vec      (btb_row[RK_LO +: BTB_WAYS*RANK_W]),
      .valid_vec     (btb_row[VL_LO +: BTB_WAYS]),
      .tag_vec       (btb_row[TG_LO +: BTB_WAYS*TAG_W]),
      .way_act       (way_act),
      .tag           (s1_tag_ff),
      .hit           (btb_hit),
      .new_rank_vec  (btb_new_row[RK_LO +: BTB_WAYS*RANK_W]),
      .new_valid_vec (btb_new_row[VL_LO +: BTB_WAYS]),
      .new_tag_vec   (btb_new_row[TG_LO +: BTB_WAYS*TAG_W])
   );

   assign btb_use   = !hybrid && btb_enable_ff;
   assign consulted = !btb_use || btb_hit;

   always_comb begin
      if (clr_active_ff) begin
         btb_wr_en   = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(BTB_SETS));
         btb_wr_addr = SET_W'(clr_cnt_ff);
         btb_wr_data = btb_rst_row;
      end else begin
         btb_wr_en   = adv && s1_valid_ff && btb_use;
         btb_wr_addr = s1_set_ff;
         btb_wr_data = btb_new_row;
      end
   end

   bpu_ram #(
      .WIDTH  (ROW_W),
      .DEPTH  (BTB_SETS),
      .ADDR_W (SET_W)
   ) u_btb_ram (
      .clock   (clock),
      .wr_en   (btb_wr_en),
      .wr_addr (btb_wr_addr),
      .wr_data (btb_wr_data),
      .rd_en   (adv),
      .rd_addr (set0),
      .rd_data (btb_rd)
   );

   // Table indices
   logic [WORD_W-1:0] word1;
   logic [TB-1:0]     word1_t;
   logic [HB-1:0]     hist;
   logic [TB-1:0]     bi_idx, gs_idx, ch_idx;
   logic              hist_we;

   always_comb begin
      word1   = s1_addr_ff[ADDRESS_BITS-1:2];
      word1_t = TB'(word1);
      hist    = hist_ff & ~({HB{1'b1}} << hn);
      bi_idx  = word1_t & ~({TB{1'b1}} << mb);
      ch_idx  = word1_t & ~({TB{1'b1}} << mk);
      gs_idx  = (word1_t & ~({TB{1'b1}} << mg)) ^ (TB'(hist) << (mg - hn));
      hist_we = adv && s1_valid_ff && (hn != 5'd0) &&
                (hybrid || ((mode_ff == bpu_pkg::MODE_GSHARE) && consulted));
      hist_in = hist_we ? ((hist >> 1) | (HB'(s1_taken_ff) << (hn - 5'd1))) : hist_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         hist_ff      <= '0;
         btb_wb_en_ff <= 1'b0;
      end else begin
         hist_ff <= hist_in;
         if (adv) begin
            s1_valid_ff  <= accept;
            btb_wb_en_ff <= s1_valid_ff && btb_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff    <= req_bus.branch_address;
         s1_taken_ff   <= req_bus.taken;
         s1_set_ff     <= set0;
         s1_tag_ff     <= tag0;
         btb_wb_set_ff <= s1_set_ff;
         btb_wb_row_ff <= btb_new_row;
      end
   end

   // ---------------- stage 2: counters ----------------
   logic                 s2_valid_ff;
   bpu_pkg::dir_ctl_type s2_ctl_ff, s1_ctl;
   logic [TB-1:0]        s2_bi_ff, s2_gs_ff, s2_ch_ff;

   bpu_pkg::cnt_type bi_rd, gs_rd, ch_rd;
   bpu_pkg::cnt_type bi_cnt, gs_cnt, ch_cnt;

   logic             bi_wb_en_ff, gs_wb_en_ff, ch_wb_en_ff;
   logic [TB-1:0]    bi_wb_addr_ff, gs_wb_addr_ff, ch_wb_addr_ff;
   bpu_pkg::cnt_type bi_wb_val_ff, gs_wb_val_ff, ch_wb_val_ff;

   bpu_pkg::dir_res_type dir_res;
   bpu_pkg::dir_wr_type  dir_wr;

   always_comb begin
      s1_ctl.hybrid    = hybrid;
      s1_ctl.gshare    = (mode_ff == bpu_pkg::MODE_GSHARE);
      s1_ctl.consulted = consulted;
      s1_ctl.taken     = s1_taken_ff;
   end

   assign bi_cnt = (bi_wb_en_ff && (bi_wb_addr_ff == s2_bi_ff)) ? bi_wb_val_ff : bi_rd;
   assign gs_cnt = (gs_wb_en_ff && (gs_wb_addr_ff == s2_gs_ff)) ? gs_wb_val_ff : gs_rd;
   assign ch_cnt = (ch_wb_en_ff && (ch_wb_addr_ff == s2_ch_ff)) ? ch_wb_val_ff : ch_rd;

   bpu_dir u_dir (
      .ctl    (s2_ctl_ff),
      .bi_cnt (bi_cnt),
      .gs_cnt (gs_cnt),
      .ch_cnt (ch_cnt),
      .res    (dir_res),
      .wr     (dir_wr)
   );

   // Counter RAM write ports
   logic             clr_tbl;
   logic             s2_go;
   logic             bi_we, gs_we, ch_we;
   logic [TB-1:0]    bi_wa, gs_wa, ch_wa;
   bpu_pkg::cnt_type bi_wd, gs_wd, ch_wd;

   always_comb begin
      clr_tbl = clr_active_ff && ({1'b0, clr_cnt_ff} < (CLR_W+1)'(TDEPTH));
      s2_go   = adv && s2_valid_ff && !clr_active_ff;
      if (clr_active_ff) begin
         bi_we = clr_tbl;
         gs_we = clr_tbl;
         ch_we = clr_tbl;
         bi_wa = TB'(clr_cnt_ff);
         gs_wa = TB'(clr_cnt_ff);
         ch_wa = TB'(clr_cnt_ff);
         bi_wd = bpu_pkg::CNT_WEAK_TAKEN;
         gs_wd = bpu_pkg::CNT_WEAK_TAKEN;
         ch_wd = bpu_pkg::CNT_WEAK_BIMODAL;
      end else begin
         bi_we = s2_go && dir_wr.bi_we;
         gs_we = s2_go && dir_wr.gs_we;
         ch_we = s2_go && dir_wr.ch_we;
         bi_wa = s2_bi_ff;
         gs_wa = s2_gs_ff;
         ch_wa = s2_ch_ff;
         bi_wd = dir_wr.bi_val;
         gs_wd = dir_wr.gs_val;
         ch_wd = dir_wr.ch_val;
      end
   end

   bpu_ram #(.WIDTH(2), .DEPTH(TDEPTH), .ADDR_W(TB)) u_bi_ram (
      .clock (clock), .wr_en (bi_we), .wr_addr (bi_wa), .wr_data (bi_wd),
      .rd_en (adv), .rd_addr (bi_idx), .rd_data (bi_rd)
   );

   bpu_ram #(.WIDTH(2), .DEPTH(TDEPTH), .ADDR_W(TB)) u_gs_ram (
      .clock (clock), .wr_en (gs_we), .wr_addr (gs_wa), .wr_data (gs_wd),
      .rd_en (adv), .rd_addr (gs_idx), .rd_data (gs_rd)
   );

   bpu_ram #(.WIDTH(2), .DEPTH(TDEPTH), .ADDR_W(TB)) u_ch_ram (
      .clock (clock), .wr_en (ch_we), .wr_addr (ch_wa), .wr_data (ch_wd),
      .rd_en (adv), .rd_addr (ch_idx), .rd_data (ch_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         bi_wb_en_ff  <= 1'b0;
         gs_wb_en_ff  <= 1'b0;
         ch_wb_en_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff  <= s1_valid_ff;
         bi_wb_en_ff  <= s2_valid_ff && dir_wr.bi_we;
         gs_wb_en_ff  <= s2_valid_ff && dir_wr.gs_we;
         ch_wb_en_ff  <= s2_valid_ff && dir_wr.ch_we;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff     <= s1_ctl;
         s2_bi_ff      <= bi_idx;
         s2_gs_ff      <= gs_idx;
         s2_ch_ff      <= ch_idx;
         bi_wb_addr_ff <= s2_bi_ff;
         gs_wb_addr_ff <= s2_gs_ff;
         ch_wb_addr_ff <= s2_ch_ff;
         bi_wb_val_ff  <= dir_wr.bi_val;
         gs_wb_val_ff  <= dir_wr.gs_val;
         ch_wb_val_ff  <= dir_wr.ch_val;
         rsp_res_ff    <= dir_res;
      end
   end

   // ---------------- result register ----------------
   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.predicted_taken     = rsp_res_ff.predicted_taken;
   assign rsp_bus.mispredicted        = rsp_res_ff.mispredicted;
   assign rsp_bus.predictor_consulted = rsp_res_ff.predictor_consulted;
   assign rsp_bus.chose_gshare        = rsp_res_ff.chose_gshare;

`ifndef NO_ASSERTIONS
   // pipeline stays empty while the RAMs are being cleared
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("transaction in flight during clearing pass");

   // a forced not-taken never reports taken
   a_forced_nt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_res_ff.predictor_consulted) |-> !rsp_res_ff.predicted_taken)
      else $error("taken reported on BTB miss");

   // a stalled result register keeps its transaction
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_res_ff)))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
